// ===== hw/rtl/tlr_pkg.sv =====
// Shared constants and types for the thick line rasterizer.
// No dependencies; every other file of the block depends on this package.
package tlr_pkg;

    // Defaults of the top-level parameters
    localparam int COORD_BITS_DEF    = 16;
    localparam int MAX_THICKNESS_DEF = 7;

    // Fixed field widths
    localparam int FRAME_W = 13;
    localparam int THICK_W = 3;
    localparam int HALF_W  = 2;   // half-size of the brush square, 0..3
    localparam int OFS_W   = 3;   // signed brush offset, -3..3

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BRUSH_THICKNESS = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST     = 13'd256;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST    = 13'd256;
    localparam logic [THICK_W-1:0] BRUSH_THICKNESS_RST = 3'd1;

    // Command codes of an input item
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Hand-off of one step from the line walker to the brush unit
    typedef struct packed {
        logic              start;   // step taken, square to be drawn
        logic [HALF_W-1:0] half;    // half-size of the square
        logic              at_end;  // current point is the end point
    } tlr_step_t;

endpackage

// ===== hw/rtl/tlr_if.sv =====
// Valid/ready channel interfaces of the thick line rasterizer.
// Depends on tlr_pkg for default widths.
interface tlr_seg_if #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface tlr_pix_if #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] pixel_x;
    logic signed [COORD_BITS:0] pixel_y;
    logic                       in_frame;
    logic                       last_of_square;
    logic                       segment_end;

    modport source (output valid, pixel_x, pixel_y, in_frame, last_of_square, segment_end,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, in_frame, last_of_square, segment_end,
                    output ready);
endinterface

// ===== hw/rtl/tlr_walker.sv =====
// Bresenham line walker: segment state, load and one step per accepted step item.
// Depends on tlr_pkg.
module tlr_walker #(
    parameter int COORD_BITS    = tlr_pkg::COORD_BITS_DEF,
    parameter int MAX_THICKNESS = tlr_pkg::MAX_THICKNESS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                cmd,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic        [tlr_pkg::THICK_W-1:0]  thickness,
    output tlr_pkg::tlr_step_t                  step,
    output logic signed [COORD_BITS-1:0]        base_x,
    output logic signed [COORD_BITS-1:0]        base_y
);
    import tlr_pkg::*;

    localparam int CW = COORD_BITS + 1;   // deltas
    localparam int EW = COORD_BITS + 3;   // error term

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] target_x_reg, target_x_next, target_y_reg, target_y_next;
    logic        [CW-1:0]         abs_dx_reg, abs_dx_next, abs_dy_reg, abs_dy_next;
    logic signed [EW-1:0]         error_term_reg, error_term_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic                         active_reg, active_next;

    logic signed [CW-1:0]  sx, sy, ex, ey;
    logic        [CW-1:0]  ld_dx, ld_dy;
    logic signed [EW:0]    e2, neg_dy, pos_dx;
    logic                  move_x, move_y;
    logic signed [EW-1:0]  add_x, add_y;
    logic [THICK_W-1:0]    t_clip;
    logic                  at_end;

    // Square size follows the thickness, limited to the largest brush
    assign t_clip = (thickness > THICK_W'(MAX_THICKNESS)) ? THICK_W'(MAX_THICKNESS) : thickness;
    assign at_end = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);

    assign step.start  = accept && (cmd == CMD_STEP) && active_reg;
    assign step.half   = t_clip[THICK_W-1:1];
    assign step.at_end = at_end;
    assign base_x      = cur_x_reg;
    assign base_y      = cur_y_reg;

    always_comb
    begin
        sx = $signed({start_x[COORD_BITS-1], start_x});
        sy = $signed({start_y[COORD_BITS-1], start_y});
        ex = $signed({end_x[COORD_BITS-1], end_x});
        ey = $signed({end_y[COORD_BITS-1], end_y});
        ld_dx = (ex > sx) ? CW'(ex - sx) : CW'(sx - ex);
        ld_dy = (ey > sy) ? CW'(ey - sy) : CW'(sy - ey);

        e2     = $signed({error_term_reg, 1'b0});
        neg_dy = -$signed({3'b000, abs_dy_reg});
        pos_dx = $signed({3'b000, abs_dx_reg});
        move_x = e2 > neg_dy;
        move_y = e2 < pos_dx;
        add_x  = move_x ? -$signed({2'b00, abs_dy_reg}) : '0;
        add_y  = move_y ?  $signed({2'b00, abs_dx_reg}) : '0;

        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        abs_dx_next     = abs_dx_reg;
        abs_dy_next     = abs_dy_reg;
        error_term_next = error_term_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        active_next     = active_reg;

        if (accept && (cmd == CMD_LOAD))
        begin
            cur_x_next      = start_x;
            cur_y_next      = start_y;
            target_x_next   = end_x;
            target_y_next   = end_y;
            abs_dx_next     = ld_dx;
            abs_dy_next     = ld_dy;
            step_x_neg_next = !(sx < ex);
            step_y_neg_next = !(sy < ey);
            error_term_next = $signed({2'b00, ld_dx}) - $signed({2'b00, ld_dy});
            active_next     = 1'b1;
        end
        else if (step.start)
        begin
            if (at_end)
            begin
                active_next = 1'b0;
            end
            else
            begin
                error_term_next = error_term_reg + add_x + add_y;
                if (move_x)
                begin
                    cur_x_next = step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            abs_dx_reg     <= '0;
            abs_dy_reg     <= '0;
            error_term_reg <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            abs_dx_reg     <= abs_dx_next;
            abs_dy_reg     <= abs_dy_next;
            error_term_reg <= error_term_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ===== hw/rtl/tlr_brush.sv =====
// Brush unit: walks the square of offsets of one step and drives the pixel channel
// through a result register. Depends on tlr_pkg and tlr_pix_if.
module tlr_brush #(
    parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tlr_pkg::tlr_step_t                 step,
    input  logic signed [COORD_BITS-1:0]       base_x,
    input  logic signed [COORD_BITS-1:0]       base_y,
    input  logic        [tlr_pkg::FRAME_W-1:0] frame_width,
    input  logic        [tlr_pkg::FRAME_W-1:0] frame_height,
    output logic                               free,
    tlr_pix_if.source                          pix
);
    import tlr_pkg::*;

    localparam int CW = COORD_BITS + 1;

    logic                         busy_reg;
    logic signed [COORD_BITS-1:0] bx_reg, by_reg;
    logic        [HALF_W-1:0]     half_reg;
    logic                         at_end_reg;
    logic signed [OFS_W-1:0]      ox_reg, ox_next, oy_reg, oy_next;

    logic                         out_valid_reg;
    logic signed [CW-1:0]         px_reg, py_reg;
    logic                         inf_reg, last_reg, end_reg;

    logic signed [OFS_W-1:0] h_s, neg_h, start_h;
    logic signed [CW-1:0]    px, py;
    logic                    inf, sq_last, adv;

    assign h_s     = $signed({1'b0, half_reg});
    assign neg_h   = -h_s;
    assign start_h = -$signed({1'b0, step.half});
    assign sq_last = (ox_reg == h_s) && (oy_reg == h_s);

    // While busy, produce a pixel whenever the result register is empty or being drained
    assign adv  = busy_reg && (!out_valid_reg || pix.ready);
    assign free = !busy_reg || (adv && sq_last);

    always_comb
    begin
        px  = $signed({bx_reg[COORD_BITS-1], bx_reg}) +
              $signed({{(CW-OFS_W){ox_reg[OFS_W-1]}}, ox_reg});
        py  = $signed({by_reg[COORD_BITS-1], by_reg}) +
              $signed({{(CW-OFS_W){oy_reg[OFS_W-1]}}, oy_reg});
        inf = !px[CW-1] && !py[CW-1] &&
              ({{FRAME_W{1'b0}}, px} < {{CW{1'b0}}, frame_width}) &&
              ({{FRAME_W{1'b0}}, py} < {{CW{1'b0}}, frame_height});

        ox_next = ox_reg;
        oy_next = oy_reg;
        if (ox_reg == h_s)
        begin
            ox_next = neg_h;
            oy_next = oy_reg + 1'b1;
        end
        else
        begin
            ox_next = ox_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (adv && sq_last)
            begin
                busy_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.start)
        begin
            bx_reg     <= base_x;
            by_reg     <= base_y;
            half_reg   <= step.half;
            at_end_reg <= step.at_end;
            ox_reg     <= start_h;
            oy_reg     <= start_h;
        end
        else if (adv)
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end

        if (adv)
        begin
            px_reg   <= px;
            py_reg   <= py;
            inf_reg  <= inf;
            last_reg <= sq_last;
            end_reg  <= at_end_reg;
        end
    end

    assign pix.valid          = out_valid_reg;
    assign pix.pixel_x        = px_reg;
    assign pix.pixel_y        = py_reg;
    assign pix.in_frame       = inf_reg;
    assign pix.last_of_square = last_reg;
    assign pix.segment_end    = end_reg;

endmodule

// ===== hw/rtl/thick_line_rasterizer.sv =====
// Top level of the thick line rasterizer: configuration registers, line walker
// and brush unit. Depends on tlr_pkg, tlr_if, tlr_walker and tlr_brush.
//
//  channel  dir  handshake       carries
//  -------  ---  --------------  ------------------------------------------------
//  seg      in   valid/ready     cmd, start_x, start_y, end_x, end_y
//  pix      out  valid/ready     pixel_x, pixel_y, in_frame, last_of_square,
//                                segment_end
//  APB      in   psel/penable    frame_width, frame_height, brush_thickness
//
// One pixel leaves per cycle while pix is ready. A step item yields (2h+1)^2
// pixels, h being brush_thickness/2, nine for 3x3; the brush offset counter
// in tlr_brush sets that figure. Load items and steps while idle take one cycle.
// The next item is taken in the cycle the last pixel of a square is produced.
// Reset is asynchronous and leaves the block idle with no pixel pending; no
// clearing pass is needed. A stall on pix holds the result register and the
// brush counter; seg stalls only while a square is still being walked.
module thick_line_rasterizer #(
    parameter int COORD_BITS    = tlr_pkg::COORD_BITS_DEF,
    parameter int MAX_THICKNESS = tlr_pkg::MAX_THICKNESS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tlr_seg_if.sink                          seg,
    tlr_pix_if.source                        pix,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tlr_pkg::*;

    logic [FRAME_W-1:0] frame_width_reg, frame_height_reg;
    logic [THICK_W-1:0] brush_thickness_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic               cfg_wr;

    logic                         accept, free;
    tlr_step_t                    step;
    logic signed [COORD_BITS-1:0] base_x, base_y;

    // Configuration port: zero wait states, index from the word address
    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= FRAME_WIDTH_RST;
            frame_height_reg    <= FRAME_HEIGHT_RST;
            brush_thickness_reg <= BRUSH_THICKNESS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[FRAME_W-1:0];
                REG_BRUSH_THICKNESS: brush_thickness_reg <= pwdata[THICK_W-1:0];
                default:             ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:     prdata = {{(APB_DATA_W-FRAME_W){1'b0}}, frame_width_reg};
            REG_FRAME_HEIGHT:    prdata = {{(APB_DATA_W-FRAME_W){1'b0}}, frame_height_reg};
            REG_BRUSH_THICKNESS: prdata = {{(APB_DATA_W-THICK_W){1'b0}}, brush_thickness_reg};
            default:             prdata = '0;
        endcase
    end

    // Input transfer: taken whenever the brush can start a new square
    assign seg.ready = free;
    assign accept    = seg.valid && free;

    tlr_walker #(
        .COORD_BITS    (COORD_BITS),
        .MAX_THICKNESS (MAX_THICKNESS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (seg.cmd),
        .start_x   (seg.start_x),
        .start_y   (seg.start_y),
        .end_x     (seg.end_x),
        .end_y     (seg.end_y),
        .thickness (brush_thickness_reg),
        .step      (step),
        .base_x    (base_x),
        .base_y    (base_y)
    );

    tlr_brush #(
        .COORD_BITS (COORD_BITS)
    ) u_brush (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .base_x       (base_x),
        .base_y       (base_y),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .free         (free),
        .pix          (pix)
    );

    // A square wider than one pixel keeps the input closed in the next cycle
    a_square_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        step.start && (step.half != '0) |=> !seg.ready)
        else $error("input reopened before the square was walked");

    // A fresh run of pixels follows a step transfer through the busy flag and the result register
    a_pixels_follow_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix.valid) |-> $past(step.start, 2))
        else $error("pixel presented without a preceding step");

    // Pixels of one square come without gaps and share the segment end flag
    a_square_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready && !pix.last_of_square |=>
            pix.valid && $stable(pix.segment_end))
        else $error("square interrupted or segment end flag changed");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for thick_line_rasterizer: segment loads and steps in,
// brush-square pixels out, checked against an in-bench line walker.
// Depends on tlr_pkg, tlr_if and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int TOTAL_ITEMS = 420;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no transfer before giving up
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // One pixel of a brush square as the block should emit it
    typedef struct packed {
        logic signed [CB:0] x;
        logic signed [CB:0] y;
        logic               in_frame;
        logic               last;
        logic               seg_end;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tlr_seg_if seg_if ();
    tlr_pix_if pix_if ();

    thick_line_rasterizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg     (seg_if),
        .pix     (pix_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line walker mirror: register copies and segment state
    // ------------------------------------------------------------------
    int frame_w = int'(FRAME_WIDTH_RST);
    int frame_h = int'(FRAME_HEIGHT_RST);
    int brush   = int'(BRUSH_THICKNESS_RST);

    int pen_x, pen_y, goal_x, goal_y;
    int run_x, run_y, err_acc;
    bit dir_x_neg, dir_y_neg, walking;

    pixel_t pending_pixels[$];   // pixels owed by the block, oldest first
    int     errors;
    int     useful_items;        // loads, and steps that drew a square
    int     send_idle_pct;
    int     recv_stall_pct;

    // Apply one accepted transfer to the walker and queue the pixels it owes.
    function automatic void walk_transfer(logic cmd, int x0, int y0, int x1, int y1);
        int     half;
        int     e2;
        int     px;
        int     py;
        bit     at_end;
        pixel_t pix;
        if (cmd == CMD_LOAD)
        begin
            // latch a fresh segment, dropping any segment in progress
            pen_x     = x0;
            pen_y     = y0;
            goal_x    = x1;
            goal_y    = y1;
            run_x     = (x1 > x0) ? x1 - x0 : x0 - x1;
            run_y     = (y1 > y0) ? y1 - y0 : y0 - y1;
            dir_x_neg = !(x0 < x1);
            dir_y_neg = !(y0 < y1);
            err_acc   = run_x - run_y;
            walking   = 1'b1;
            useful_items++;
        end
        else if (walking)
        begin
            useful_items++;
            half   = brush / 2;
            at_end = (pen_x == goal_x) && (pen_y == goal_y);
            // row-major square: y outer, x inner, both ascending
            for (int oy = -half; oy <= half; oy++)
            begin
                for (int ox = -half; ox <= half; ox++)
                begin
                    px           = pen_x + ox;
                    py           = pen_y + oy;
                    pix.x        = px[CB:0];
                    pix.y        = py[CB:0];
                    pix.in_frame = (px >= 0) && (py >= 0) && (px < frame_w) && (py < frame_h);
                    pix.last     = (oy == half) && (ox == half);
                    pix.seg_end  = at_end;
                    pending_pixels.push_back(pix);
                end
            end
            if (at_end)
            begin
                walking = 1'b0;
            end
            else
            begin
                // one Bresenham step; both tests use the error before the step
                e2 = 2 * err_acc;
                if (e2 > -run_y)
                begin
                    err_acc -= run_y;
                    pen_x   += dir_x_neg ? -1 : 1;
                end
                if (e2 < run_x)
                begin
                    err_acc += run_x;
                    pen_y   += dir_y_neg ? -1 : 1;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on every seg transfer, check every pix transfer.
    // Prediction runs first so a transfer is queued before any pixel of it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        pixel_t want;
        if (rst_n && seg_if.valid && seg_if.ready)
        begin
            walk_transfer(seg_if.cmd, seg_if.start_x, seg_if.start_y,
                          seg_if.end_x, seg_if.end_y);
        end
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel: expected none, %s",
                         $time, "got:");
                $display("    x=%0d y=%0d f=%0b l=%0b e=%0b",
                         pix_if.pixel_x, pix_if.pixel_y, pix_if.in_frame,
                         pix_if.last_of_square, pix_if.segment_end);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_if.pixel_x !== want.x || pix_if.pixel_y !== want.y ||
                    pix_if.in_frame !== want.in_frame ||
                    pix_if.last_of_square !== want.last ||
                    pix_if.segment_end !== want.seg_end)
                begin
                    errors++;
                    $display("%0t: pixel mismatch: expected x=%0d y=%0d f=%0b l=%0b e=%0b",
                             $time, want.x, want.y, want.in_frame, want.last,
                             want.seg_end);
                    $display("    got x=%0d y=%0d f=%0b l=%0b e=%0b",
                             pix_if.pixel_x, pix_if.pixel_y, pix_if.in_frame,
                             pix_if.last_of_square, pix_if.segment_end);
                end
            end
        end
    end

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
    begin
        pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((seg_if.valid && seg_if.ready) || (pix_if.valid && pix_if.ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one seg transfer and hold it until the block takes it.
    // valid stays high on return so back-to-back items need no extra edge.
    task automatic send_item(logic cmd, int x0, int y0, int x1, int y1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg_if.valid <= 1'b0;
            @(posedge clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.cmd     <= cmd;
        seg_if.start_x <= x0[CB-1:0];
        seg_if.start_y <= y0[CB-1:0];
        seg_if.end_x   <= x1[CB-1:0];
        seg_if.end_y   <= y1[CB-1:0];
        do @(posedge clk); while (!seg_if.ready);
    endtask

    task automatic send_load(int x0, int y0, int x1, int y1);
        send_item(CMD_LOAD, x0, y0, x1, y1);
    endtask

    // Coordinates of a step are don't-care; toggle them anyway
    task automatic send_step();
        send_item(CMD_STEP, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Load a segment and step exactly to its end point
    task automatic walk_segment(int x0, int y0, int x1, int y1);
        int dx;
        int dy;
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        send_load(x0, y0, x1, y1);
        repeat (((dx > dy) ? dx : dy) + 1) send_step();
    endtask

    // Drop valid and hold off until every owed pixel has arrived, then let the
    // block settle past any load or idle step still in flight.
    task automatic wait_drained();
        seg_if.valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:     frame_w = int'(value[FRAME_W-1:0]);
            REG_FRAME_HEIGHT:    frame_h = int'(value[FRAME_W-1:0]);
            REG_BRUSH_THICKNESS: brush   = int'(value[THICK_W-1:0]);
            default:             ;   // unmapped index: no register changes
        endcase
    endtask

    // Write all three registers; junk in the unused upper bits must be dropped
    task automatic set_config(int w, int h, int t);
        apb_write(REG_FRAME_WIDTH,     ($urandom() << FRAME_W) | w);
        apb_write(REG_FRAME_HEIGHT,    ($urandom() << FRAME_W) | h);
        apb_write(REG_BRUSH_THICKNESS, ($urandom() << THICK_W) | t);
    endtask

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Mostly around the frame so clipping flips, some at the coordinate
    // extremes, some anywhere
    function automatic int pick_coord(int span);
        int r;
        r = $urandom_range(9);
        if (r < 5)
            return int'($urandom_range(span + 8)) - 4;
        if (r < 7)
            return int'($urandom_range(8)) - 32768;
        if (r < 9)
            return 32767 - int'($urandom_range(8));
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: step while idle, a short walk with a single-pixel brush,
    // and a step past the end point
    task automatic test_idle_and_defaults();
        send_step();
        walk_segment(0, 0, 2, 1);
        send_step();
        wait_drained();
    endtask

    // Coordinate extremes, zero-length segments, steps with x falling and y rising,
    // x rising alone and y falling alone, and a load that drops a segment part way
    task automatic test_directed_cases();
        set_config(4096, 4096, 7);
        walk_segment(-32768, -32768, -32768, -32768);
        walk_segment(32767, 32767, 32767, 32767);
        walk_segment(32767, -32768, 32764, -32766);
        send_load(3, 3, 10, 3);
        send_step();
        send_step();
        walk_segment(-2, 5, -2, 1);
        wait_drained();
    endtask

    // Frame and brush extremes, including zero-size and oversize frames and
    // a write to an unmapped register
    task automatic test_config_extremes();
        int settings [6][3] = '{'{1, 1, 0}, '{0, 0, 2}, '{4096, 4096, 7},
                                '{8191, 8191, 3}, '{256, 1, 5}, '{1, 4096, 1}};
        apb_write(REG_UNMAPPED, $urandom());
        foreach (settings[i])
        begin
            set_config(settings[i][0], settings[i][1], settings[i][2]);
            walk_segment(-2, -1, 2, 1);
            wait_drained();
        end
    endtask

    task automatic random_config();
        int w;
        int h;
        int t;
        w = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 4096);
        h = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(1, 4096);
        t = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(3);
        set_config(w, h, t);
    endtask

    // Mostly complete short segments; the rest truncated walks and noise
    task automatic random_segment();
        int x0;
        int y0;
        int x1;
        int y1;
        int kind;
        kind = $urandom_range(99);
        x0   = pick_coord(frame_w);
        y0   = pick_coord(frame_h);
        x1   = clamp_coord(x0 + int'($urandom_range(12)) - 6);
        y1   = clamp_coord(y0 + int'($urandom_range(12)) - 6);
        if (kind < 70)
        begin
            walk_segment(x0, y0, x1, y1);
            if ($urandom_range(9) == 0)
                send_step();
        end
        else if (kind < 85)
        begin
            // cut short; the next load drops it
            send_load(x0, y0, x1, y1);
            repeat ($urandom_range(2)) send_step();
        end
        else
        begin
            // any command, any coordinates: usually a segment far too long to finish
            send_item(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), $urandom());
            repeat ($urandom_range(3)) send_step();
        end
    endtask

    // Four flow-control phases, each with its own register setting
    task automatic test_random_walks();
        int phase_idle  [4] = '{0, 62, 0, 7};
        int phase_stall [4] = '{0, 0, 62, 7};
        int quota;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            random_config();
            quota = useful_items + (TOTAL_ITEMS - useful_items) / (4 - p);
            while (useful_items < quota)
            begin
                random_segment();
                // now and then hold the sender until the pipe is empty
                if ($urandom_range(19) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        seg_if.valid   = 1'b0;
        seg_if.cmd     = CMD_LOAD;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.end_x   = '0;
        seg_if.end_y   = '0;
        pix_if.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_defaults();
        test_directed_cases();
        test_config_extremes();
        test_random_walks();

        // drain and give the block time to emit anything stray
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== thick_line_rasterizer.f =====
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_if.sv
hw/rtl/tlr_walker.sv
hw/rtl/tlr_brush.sv
hw/rtl/thick_line_rasterizer.sv
tb/tb_top.sv
